FILE: src/clp_pkg.sv
`default_nettype none

package clp_pkg;

  // field widths
  localparam int PERM_W  = 16;
  localparam int PATCH_W = 16;
  localparam int SYN_W   = 4;
  localparam int COL_W   = 10;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 2;

  // step tag stored per column, zero marks a column never active
  localparam int TAG_W = 32;

  // 1.0 in Q1.15
  localparam logic [PERM_W-1:0] PERM_ONE = 16'd32768;
  localparam logic [PERM_W-1:0] PERM_RESET_STEP = 16'd3277;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_ACTIVE   = 2'd2,
    CMD_END_STEP = 2'd3
  } cmd_t;

  typedef enum logic [CFG_W-1:0] {
    REG_INC     = 2'd0,
    REG_DEC_NEW = 2'd1,
    REG_DEC_REP = 2'd2,
    REG_NONE    = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: src/column_permanence_learner.sv
`default_nettype none

// channel  signals                                      transfer when
// -------  -------------------------------------------  ----------------------
// in       in_valid in_ready command column synapse     in_valid & in_ready
//          perm_in patch_bits
// out      out_valid out_ready perm_out synapse_out     out_valid & out_ready
//          updated last
// cfg      cfg_write cfg_index cfg_data                 cfg_write
//
// write and end of step leave in_ready high; a read passes through RD_WAIT and
// the output register before its result; an active column first reads the
// column record in ACT_META, then walks one synapse per cycle while the output
// is not stalled, through the shared saturating add/subtract unit on the single
// permanence memory port pair; after reset a clearing pass writes every column
// record memory entry; in_ready stays low until it ends
// a stalled output register holds the synapse walk where it is

module column_permanence_learner #(
  parameter int NUM_COLUMNS  = 1024,
  parameter int NUM_SYNAPSES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [clp_pkg::CMD_W-1:0]    command,
  input  wire logic [clp_pkg::COL_W-1:0]    column,
  input  wire logic [clp_pkg::SYN_W-1:0]    synapse,
  input  wire logic [clp_pkg::PERM_W-1:0]   perm_in,
  input  wire logic [clp_pkg::PATCH_W-1:0]  patch_bits,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [clp_pkg::PERM_W-1:0]   perm_out,
  output logic      [clp_pkg::SYN_W-1:0]    synapse_out,
  output logic                              updated,
  output logic                              last,
  input  wire logic                         cfg_write,
  input  wire logic [clp_pkg::CFG_W-1:0]    cfg_index,
  input  wire logic [clp_pkg::PERM_W-1:0]   cfg_data
);

  import clp_pkg::*;

  localparam int SYN_COUNT  = (NUM_SYNAPSES < 16) ? NUM_SYNAPSES : 16;
  localparam int PERM_DEPTH = NUM_COLUMNS * SYN_COUNT;
  localparam int PA_W       = (PERM_DEPTH > 1) ? $clog2(PERM_DEPTH) : 1;
  localparam int CA_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int REC_W      = PATCH_W + TAG_W + 1;
  localparam logic [PATCH_W-1:0] PATCH_MASK =
    PATCH_W'((33'd1 << SYN_COUNT) - 33'd1);
  localparam logic [SYN_W-1:0] SYN_LAST = SYN_W'(SYN_COUNT - 1);
  localparam logic [CA_W-1:0]  CLR_LAST = CA_W'(NUM_COLUMNS - 1);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    RD_WAIT,
    ACT_META,
    ACT_SYN
  } state_t;

  state_t state;

  // configuration
  logic [PERM_W-1:0] perm_increment;
  logic [PERM_W-1:0] perm_decrement_new;
  logic [PERM_W-1:0] perm_decrement_repeat;

  // sequencer registers
  logic [CA_W-1:0]    clr_ptr;
  logic [TAG_W-1:0]   epoch;
  logic [TAG_W-1:0]   epoch_prev;
  logic [CA_W-1:0]    col_q;
  logic [PATCH_W-1:0] patch_q;
  logic [SYN_W-1:0]   syn_q;
  logic               rd_ok_q;
  logic [PA_W-1:0]    perm_ptr;
  logic               learn_q;
  logic [PERM_W-1:0]  dec_q;

  // memory ports
  logic               pw_en;
  logic [PA_W-1:0]    pw_addr;
  logic [PERM_W-1:0]  pw_data;
  logic               pr_en;
  logic [PA_W-1:0]    pr_addr;
  logic [PERM_W-1:0]  pr_data;
  logic               cw_en;
  logic [CA_W-1:0]    cw_addr;
  logic [REC_W-1:0]   cw_data;
  logic               cr_en;
  logic [REC_W-1:0]   cr_data;

  // decoded input
  logic               in_fire;
  logic               out_free;
  logic               col_ok;
  logic               syn_ok;
  logic [PERM_W-1:0]  pin_sat;
  logic [PA_W-1:0]    in_addr;
  logic [PA_W-1:0]    in_base;
  logic [PATCH_W-1:0] patch_in;

  // column record fields
  logic [PATCH_W-1:0] rec_patch;
  logic [TAG_W-1:0]   rec_tag;
  logic               rec_was;
  logic               was_now;

  // shared update unit
  logic [PERM_W:0]    sum;
  logic [PERM_W-1:0]  up_val;
  logic [PERM_W-1:0]  dn_val;
  logic [PERM_W-1:0]  new_val;
  logic               syn_last;

  assign in_ready = (state == IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // input decode
  always_comb begin
    col_ok   = 17'(column) < 17'(NUM_COLUMNS);
    syn_ok   = 5'(synapse) < 5'(SYN_COUNT);
    pin_sat  = (perm_in > PERM_ONE) ? PERM_ONE : perm_in;
    in_base  = PA_W'(32'(column) * 32'(SYN_COUNT));
    in_addr  = PA_W'(32'(column) * 32'(SYN_COUNT) + 32'(synapse));
    patch_in = patch_bits & PATCH_MASK;
  end

  // column record: {last patch, step tag, was-active flag at that tag}
  always_comb begin
    rec_patch = cr_data[REC_W-1 -: PATCH_W];
    rec_tag   = cr_data[TAG_W:1];
    rec_was   = cr_data[0];
    was_now   = (rec_tag == epoch_prev) || ((rec_tag == epoch) && rec_was);
  end

  // saturating add or subtract of one synapse
  always_comb begin
    sum      = (PERM_W + 1)'(pr_data) + (PERM_W + 1)'(perm_increment);
    up_val   = (sum > (PERM_W + 1)'(PERM_ONE)) ? PERM_ONE : sum[PERM_W-1:0];
    dn_val   = (pr_data > dec_q) ? (pr_data - dec_q) : '0;
    new_val  = learn_q ? (patch_q[syn_q] ? up_val : dn_val) : pr_data;
    syn_last = (syn_q == SYN_LAST);
  end

  // memory port control
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = perm_ptr;
    pw_data = new_val;
    pr_en   = 1'b0;
    pr_addr = PA_W'(perm_ptr + 1'b1);
    cw_en   = 1'b0;
    cw_addr = col_q;
    cw_data = {patch_q, epoch, was_now};
    cr_en   = 1'b0;
    unique case (state)
      CLEAR: begin
        cw_en   = 1'b1;
        cw_addr = clr_ptr;
        cw_data = '0;
      end
      IDLE: begin
        if (in_fire) begin
          case (command)
            CMD_WRITE: begin
              pw_en   = col_ok && syn_ok;
              pw_addr = in_addr;
              pw_data = pin_sat;
            end
            CMD_READ: begin
              pr_en   = col_ok && syn_ok;
              pr_addr = in_addr;
            end
            CMD_ACTIVE: begin
              pr_en   = col_ok;
              pr_addr = in_base;
              cr_en   = col_ok;
            end
            default: begin
            end
          endcase
        end
      end
      ACT_META: begin
        cw_en = 1'b1;
      end
      ACT_SYN: begin
        if (out_free) begin
          pw_en = learn_q;
          pr_en = !syn_last;
        end
      end
      default: begin
      end
    endcase
  end

  clp_ram #(
    .WIDTH (PERM_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk     (clk),
    .wr_en   (pw_en),
    .wr_addr (pw_addr),
    .wr_data (pw_data),
    .rd_en   (pr_en),
    .rd_addr (pr_addr),
    .rd_data (pr_data)
  );

  clp_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_COLUMNS)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (cw_en),
    .wr_addr (cw_addr),
    .wr_data (cw_data),
    .rd_en   (cr_en),
    .rd_addr (CA_W'(column)),
    .rd_data (cr_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_increment        <= PERM_RESET_STEP;
      perm_decrement_new    <= PERM_RESET_STEP;
      perm_decrement_repeat <= PERM_RESET_STEP;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INC:     perm_increment        <= cfg_data;
        REG_DEC_NEW: perm_decrement_new    <= cfg_data;
        REG_DEC_REP: perm_decrement_repeat <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      clr_ptr    <= '0;
      epoch      <= TAG_W'(1);
      epoch_prev <= '1;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clr_ptr <= CA_W'(clr_ptr + 1'b1);
          if (clr_ptr == CLR_LAST) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_fire) begin
            col_q    <= CA_W'(column);
            patch_q  <= patch_in;
            syn_q    <= synapse;
            rd_ok_q  <= col_ok && syn_ok;
            perm_ptr <= in_base;
            case (command)
              CMD_READ: begin
                state <= RD_WAIT;
              end
              CMD_ACTIVE: begin
                if (col_ok) begin
                  state <= ACT_META;
                end
              end
              CMD_END_STEP: begin
                // step tags skip zero, which marks a column never active
                epoch_prev <= epoch;
                epoch      <= (epoch == '1) ? TAG_W'(1) : TAG_W'(epoch + 1'b1);
              end
              default: begin
              end
            endcase
          end
        end
        RD_WAIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            perm_out    <= rd_ok_q ? pr_data : '0;
            synapse_out <= syn_q;
            updated     <= 1'b0;
            last        <= 1'b1;
            state       <= IDLE;
          end
        end
        ACT_META: begin
          learn_q <= !was_now || (rec_patch != patch_q);
          dec_q   <= was_now ? perm_decrement_repeat : perm_decrement_new;
          syn_q   <= '0;
          state   <= ACT_SYN;
        end
        ACT_SYN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            perm_out    <= new_val;
            synapse_out <= syn_q;
            updated     <= learn_q;
            last        <= syn_last;
            perm_ptr    <= PA_W'(perm_ptr + 1'b1);
            syn_q       <= SYN_W'(syn_q + 1'b1);
            if (syn_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an in-range active column always starts its record lookup
  a_active_start: assert property (@(posedge clk) disable iff (rst)
    in_fire && (command == CMD_ACTIVE) && col_ok |=> state == ACT_META)
    else $error("active column did not start its record lookup");

  // the final synapse ends the walk with a last result
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == ACT_SYN) && out_free && syn_last |=>
      (state == IDLE) && out_valid && last)
    else $error("synapse walk did not end with a last result");

  // next-synapse prefetch never collides with the write-back
  a_port_split: assert property (@(posedge clk) disable iff (rst)
    pw_en && pr_en |-> pw_addr != pr_addr)
    else $error("permanence read and write at the same address");

  // no result leaves during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == CLEAR |-> !out_valid && !pw_en)
    else $error("activity during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: src/clp_ram.sv
`default_nettype none

module clp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read data holds without rd_en
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import clp_pkg::*;

  localparam int SYNS      = 16;
  localparam int COLS      = 1024;
  localparam int POOL_SIZE = 8;
  localparam int MAX_GAP   = 18;
  // settle time after the last result, covers one full active column walk
  localparam int SETTLE    = 30;

  typedef struct packed {
    logic [PERM_W-1:0] perm;
    logic [SYN_W-1:0]  syn;
    logic              upd;
    logic              last;
  } perm_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    command;
  logic [COL_W-1:0]    column;
  logic [SYN_W-1:0]    synapse;
  logic [PERM_W-1:0]   perm_in;
  logic [PATCH_W-1:0]  patch_bits;
  logic                out_valid;
  logic                out_ready;
  logic [PERM_W-1:0]   perm_out;
  logic [SYN_W-1:0]    synapse_out;
  logic                updated;
  logic                last;
  logic                cfg_write;
  logic [CFG_W-1:0]    cfg_index;
  logic [PERM_W-1:0]   cfg_data;

  column_permanence_learner u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .column      (column),
    .synapse     (synapse),
    .perm_in     (perm_in),
    .patch_bits  (patch_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .perm_out    (perm_out),
    .synapse_out (synapse_out),
    .updated     (updated),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // mirror of the learner state
  logic [PERM_W-1:0]  mem_perm [0:COLS*SYNS-1];
  bit                 perm_known [0:COLS*SYNS-1];
  int                 known_idx[$];
  logic [PATCH_W-1:0] mem_patch [0:COLS-1];
  bit                 patch_known [0:COLS-1];
  logic [COLS-1:0]    was_on;
  logic [COLS-1:0]    now_on;
  logic [PERM_W-1:0]  inc_amt;
  logic [PERM_W-1:0]  dec_new_amt;
  logic [PERM_W-1:0]  dec_rep_amt;

  perm_result_t pending_perms[$];
  int           pool [POOL_SIZE] = '{0, 1, 2, 3, 341, 682, 1022, 1023};

  bit send_idle_on;
  bit recv_idle_on;
  int err_count;
  int n_items;
  int n_results;
  int n_reg_writes;
  int n_learn;
  int n_hold;

  // clock and reset
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(10_000_000);
    $display("timeout with %0d results still pending", pending_perms.size());
    $display("*** FAILED ***");
    $finish;
  end

  // apply one accepted command to the mirror and queue its results
  task automatic learn_step(input cmd_t c, input logic [COL_W-1:0] col,
                            input logic [SYN_W-1:0] syn, input logic [PERM_W-1:0] pin,
                            input logic [PATCH_W-1:0] patch);
    int            idx;
    int            s;
    logic [16:0]   p;
    logic [PERM_W-1:0] dec;
    bit            learn;
    perm_result_t  r;
    // column and synapse fields cannot exceed the array sizes at this configuration
    idx = int'({col, syn});
    case (c)
      CMD_WRITE: begin
        mem_perm[idx] = (pin > PERM_ONE) ? PERM_ONE : pin;
        if (!perm_known[idx]) begin
          perm_known[idx] = 1'b1;
          known_idx.push_back(idx);
        end
      end
      CMD_READ: begin
        r.perm = mem_perm[idx];
        r.syn  = syn;
        r.upd  = 1'b0;
        r.last = 1'b1;
        pending_perms.push_back(r);
      end
      CMD_ACTIVE: begin
        learn = !was_on[col] || (mem_patch[col] != patch);
        dec   = was_on[col] ? dec_rep_amt : dec_new_amt;
        if (learn) n_learn++;
        else n_hold++;
        for (s = 0; s < SYNS; s++) begin
          p = {1'b0, mem_perm[col*SYNS+s]};
          if (learn) begin
            // saturate at 1.0 going up and at zero going down
            if (patch[s]) begin
              p = p + inc_amt;
              if (p > PERM_ONE) p = {1'b0, PERM_ONE};
            end else begin
              p = (p > dec) ? p - dec : 17'd0;
            end
            mem_perm[col*SYNS+s] = p[PERM_W-1:0];
          end
          r.perm = p[PERM_W-1:0];
          r.syn  = s[SYN_W-1:0];
          r.upd  = learn;
          r.last = (s == SYNS - 1);
          pending_perms.push_back(r);
        end
        mem_patch[col]   = patch;
        patch_known[col] = 1'b1;
        now_on[col]      = 1'b1;
      end
      default: begin
        was_on = now_on;
        now_on = '0;
      end
    endcase
  endtask

  function automatic int draw_gap(input bit on);
    return on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // one input transfer; caller sits on a rising edge
  task automatic send_item(input cmd_t c, input logic [COL_W-1:0] col,
                           input logic [SYN_W-1:0] syn, input logic [PERM_W-1:0] pin,
                           input logic [PATCH_W-1:0] patch);
    int gap;
    gap = draw_gap(send_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= c;
    column     <= col;
    synapse    <= syn;
    perm_in    <= pin;
    patch_bits <= patch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    learn_step(c, col, syn, pin, patch);
    n_items++;
  endtask

  task automatic do_write(input int col, input int syn, input logic [PERM_W-1:0] pin);
    send_item(CMD_WRITE, col[COL_W-1:0], syn[SYN_W-1:0], pin, PATCH_W'($urandom));
  endtask

  task automatic do_read(input int col, input int syn);
    send_item(CMD_READ, col[COL_W-1:0], syn[SYN_W-1:0], PERM_W'($urandom),
              PATCH_W'($urandom));
  endtask

  task automatic do_active(input int col, input logic [PATCH_W-1:0] patch);
    send_item(CMD_ACTIVE, col[COL_W-1:0], SYN_W'($urandom), PERM_W'($urandom), patch);
  endtask

  task automatic do_end_step();
    send_item(CMD_END_STEP, COL_W'($urandom), SYN_W'($urandom), PERM_W'($urandom),
              PATCH_W'($urandom));
  endtask

  // hold the sender until every result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_perms.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [PERM_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_INC:     inc_amt = val;
      REG_DEC_NEW: dec_new_amt = val;
      REG_DEC_REP: dec_rep_amt = val;
      default: ;
    endcase
    n_reg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(input logic [PERM_W-1:0] inc, input logic [PERM_W-1:0] dnew,
                           input logic [PERM_W-1:0] drep);
    wait_idle();
    write_reg(REG_INC, inc);
    write_reg(REG_DEC_NEW, dnew);
    write_reg(REG_DEC_REP, drep);
  endtask

  function automatic logic [PERM_W-1:0] pick_perm();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return PERM_W'($urandom);
    if (r == 1) return ($urandom_range(0, 1) != 0) ? PERM_ONE : 16'd0;
    return PERM_W'($urandom_range(0, 32768));
  endfunction

  function automatic logic [PERM_W-1:0] pick_gain(input bit wide);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 16'd0;
    if (r == 1) return PERM_ONE;
    return wide ? PERM_W'($urandom_range(0, 32768)) : PERM_W'($urandom_range(0, 8000));
  endfunction

  // reuse the stored patch in four of ten draws so still-active columns sometimes hold
  function automatic logic [PATCH_W-1:0] pick_patch(input int col);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && patch_known[col]) return mem_patch[col];
    if (r == 4) return 16'h0000;
    if (r == 5) return 16'hFFFF;
    return PATCH_W'($urandom);
  endfunction

  // extremes of the fields on the top column, every command, repeated
  // activity in a step, hold on unchanged patch and saturating writes
  task automatic test_directed();
    logic [PERM_W-1:0] seed_vals [SYNS] = '{16'd0, 16'd32768, 16'd65535, 16'd32767,
                                            16'd1, 16'd16384, 16'd3276, 16'd3277,
                                            16'd29491, 16'd65534, 16'd100, 16'd0,
                                            16'd32768, 16'd12345, 16'd20000, 16'd500};
    int s;
    for (s = 0; s < SYNS; s++) do_write(COLS - 1, s, seed_vals[s]);
    do_read(COLS - 1, 2);
    do_read(COLS - 1, 0);
    do_read(COLS - 1, SYNS - 1);
    do_active(COLS - 1, 16'hFFFF);
    do_active(COLS - 1, 16'hFFFF);
    do_end_step();
    do_active(COLS - 1, 16'hFFFF);
    do_active(COLS - 1, 16'h0000);
    do_end_step();
    do_end_step();
    do_active(COLS - 1, 16'h0000);
    do_read(COLS - 1, 0);
  endtask

  // gains at full scale and at zero, plus the unused register index
  task automatic test_gain_extremes();
    set_gains(PERM_ONE, PERM_ONE, 16'd0);
    do_active(COLS - 1, 16'h00FF);
    do_end_step();
    do_active(COLS - 1, 16'h0F0F);
    set_gains(16'd0, 16'd0, PERM_ONE);
    write_reg(REG_NONE, 16'h1234);
    do_end_step();
    do_end_step();
    do_active(COLS - 1, 16'h5555);
    do_end_step();
    do_active(COLS - 1, 16'hAAAA);
    wait_idle();
  endtask

  task automatic random_item();
    int r;
    int idx;
    int col;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      col = pool[$urandom_range(0, POOL_SIZE - 1)];
      do_active(col, pick_patch(col));
    end else if (r < 60) begin
      do_end_step();
    end else if (r < 75) begin
      idx = known_idx[$urandom_range(0, known_idx.size() - 1)];
      do_read(idx / SYNS, idx % SYNS);
    end else begin
      col = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                      : $urandom_range(0, COLS - 1);
      do_write(col, $urandom_range(0, SYNS - 1), pick_perm());
    end
  endtask

  // seed a pool of columns, then random phases under changing gains and idling
  task automatic test_random_traffic();
    int c;
    int s;
    int ph;
    int k;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    for (c = 0; c < POOL_SIZE; c++)
      for (s = 0; s < SYNS; s++) do_write(pool[c], s, pick_perm());
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_gains(pick_gain(1'b0), pick_gain(1'b0), pick_gain(1'b0));
        1: set_gains(PERM_W'($urandom_range(0, 32768)), PERM_W'($urandom_range(0, 32768)),
                     PERM_W'($urandom_range(0, 32768)));
        2: set_gains(pick_gain(1'b1), pick_gain(1'b1), pick_gain(1'b1));
        default: set_gains(PERM_RESET_STEP, PERM_RESET_STEP, PERM_RESET_STEP);
      endcase
      send_idle_on = (ph != 0) && (ph != 2);
      recv_idle_on = (ph != 0) && (ph != 1);
      for (k = 0; k < 78; k++) random_item();
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // result side: random stall per result, compare with the oldest expectation
  initial begin : result_check
    int           stall;
    perm_result_t exp_r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(recv_idle_on);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_results++;
      if (pending_perms.size() == 0) begin
        $error("unexpected result transfer: perm_out %0d synapse_out %0d", perm_out,
               synapse_out);
        err_count++;
      end else begin
        exp_r = pending_perms.pop_front();
        if (perm_out !== exp_r.perm) begin
          $error("perm_out expected %0d actual %0d", exp_r.perm, perm_out);
          err_count++;
        end
        if (synapse_out !== exp_r.syn) begin
          $error("synapse_out expected %0d actual %0d", exp_r.syn, synapse_out);
          err_count++;
        end
        if (updated !== exp_r.upd) begin
          $error("updated expected %0d actual %0d", exp_r.upd, updated);
          err_count++;
        end
        if (last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, last);
          err_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_WRITE;
    column       = '0;
    synapse      = '0;
    perm_in      = '0;
    patch_bits   = '0;
    out_ready    = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = REG_INC;
    cfg_data     = '0;
    was_on       = '0;
    now_on       = '0;
    inc_amt      = PERM_RESET_STEP;
    dec_new_amt  = PERM_RESET_STEP;
    dec_rep_amt  = PERM_RESET_STEP;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    err_count    = 0;
    n_items      = 0;
    n_results    = 0;
    n_reg_writes = 0;
    n_learn      = 0;
    n_hold       = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_gain_extremes();
    test_random_traffic();
    wait_idle();

    $display("covered %0d commands, %0d result transfers, %0d register writes",
             n_items, n_results, n_reg_writes);
    $display("active columns: %0d learned, %0d held on an unchanged patch", n_learn, n_hold);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: column_permanence_learner.f
src/clp_pkg.sv
src/clp_ram.sv
src/column_permanence_learner.sv
verif/tb.sv
